@@ rtl/nad_pkg.sv @@
// Package for the notification attribute deframer.
// Holds the walk phase, status codes and the queue entry shared by all modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nad_pkg;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_ATTR_HDR = 5'b00010,
    PH_TEXT     = 5'b00100,
    PH_TAIL     = 5'b01000,
    PH_REJECT   = 5'b10000
  } phase_e;

  localparam logic [2:0] ST_COMPLETE    = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_BAD_CMD     = 3'd2;
  localparam logic [2:0] ST_MISMATCH    = 3'd3;
  localparam logic [2:0] ST_NO_ATTR_HDR = 3'd4;
  localparam logic [2:0] ST_NO_TEXT     = 3'd5;

  localparam logic [2:0] HdrLastCnt = 3'd4;

  localparam logic [1:0] AhId    = 2'd0;
  localparam logic [1:0] AhLenLo = 2'd1;

  localparam logic OutText   = 1'b0;
  localparam logic OutStatus = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  typedef struct packed {
    logic        has_text;
    logic        has_status;
    logic [7:0]  attr_id;
    logic [7:0]  text_byte;
    logic [5:0]  text_index;
    logic [2:0]  status;
    logic [31:0] uid;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/nad_if.sv @@
// Channel interfaces of the notification attribute deframer.
// Input bytes, result items and the identifier write port; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface nad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface nad_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  attr_id;
  logic [7:0]  text_byte;
  logic [5:0]  text_index;
  logic [2:0]  status;
  logic [31:0] packet_uid;
  logic        out_last;
  modport source (output valid, output out_kind, output attr_id, output text_byte,
                  output text_index, output status, output packet_uid,
                  output out_last, input ready);
  modport sink (input valid, input out_kind, input attr_id, input text_byte,
                input text_index, input status, input packet_uid,
                input out_last, output ready);
endinterface

interface nad_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_uid;
  modport source (output valid, output expected_uid, input ready);
  modport sink (input valid, input expected_uid, output ready);
endinterface

`default_nettype wire

@@ rtl/nad_front.sv @@
// Front part: accepts packet bytes, walks header and attributes, and builds queue entries.
// Depends on nad_pkg and nad_in_if.
`timescale 1ns / 1ps
`default_nettype none

module nad_front #(
  parameter int unsigned ATTR_COUNT = 5,
  parameter int unsigned TEXT_CAP   = 64
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  nad_in_if.sink          in_i,
  input  wire [31:0]      expected_uid_i,
  input  wire             full_i,
  output logic            push_o,
  output nad_pkg::entry_t entry_o
);

  localparam int unsigned IdxW = $clog2(TEXT_CAP);

  nad_pkg::phase_e phase_q, phase_d;
  logic [2:0]      hdr_cnt_q, hdr_cnt_d;
  logic [31:0]     uid_q, uid_d;
  logic [2:0]      attrs_q, attrs_d;
  logic [7:0]      attr_q, attr_d;
  logic [15:0]     len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [2:0]      held_q, held_d;
  logic            accept;
  logic            has_text;
  logic [2:0]      status;
  logic [15:0]     idx_ext;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign idx_ext    = 16'(idx_q);

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    uid_d     = uid_q;
    attrs_d   = attrs_q;
    attr_d    = attr_q;
    len_d     = len_q;
    idx_d     = idx_q;
    held_d    = held_q;
    has_text  = 1'b0;
    case (phase_q)
      nad_pkg::PH_HEADER: begin
        if (hdr_cnt_q == 3'd0) begin
          if (in_i.in_byte != 8'd0) held_d = nad_pkg::ST_BAD_CMD;
        end else begin
          uid_d = uid_q | (32'(in_i.in_byte) << {hdr_cnt_q[1:0] - 2'd1, 3'b000});
        end
        hdr_cnt_d = hdr_cnt_q + 3'd1;
        if (hdr_cnt_q == nad_pkg::HdrLastCnt) begin
          hdr_cnt_d = 3'd0;
          if (held_d == nad_pkg::ST_COMPLETE && uid_d != expected_uid_i) begin
            held_d = nad_pkg::ST_MISMATCH;
          end
          phase_d = (held_d != nad_pkg::ST_COMPLETE) ? nad_pkg::PH_REJECT
                                                     : nad_pkg::PH_ATTR_HDR;
        end
      end
      nad_pkg::PH_ATTR_HDR: begin
        if (hdr_cnt_q[1:0] == nad_pkg::AhId) begin
          attr_d    = in_i.in_byte;
          hdr_cnt_d = 3'd1;
        end else if (hdr_cnt_q[1:0] == nad_pkg::AhLenLo) begin
          len_d     = {8'd0, in_i.in_byte};
          hdr_cnt_d = 3'd2;
        end else begin
          len_d     = {in_i.in_byte, len_q[7:0]};
          idx_d     = '0;
          hdr_cnt_d = 3'd0;
          if (len_d == 16'd0) begin
            attrs_d = attrs_q + 3'd1;
            phase_d = (attrs_d >= 3'(ATTR_COUNT)) ? nad_pkg::PH_TAIL : nad_pkg::PH_ATTR_HDR;
          end else begin
            phase_d = nad_pkg::PH_TEXT;
          end
        end
      end
      nad_pkg::PH_TEXT: begin
        has_text = (idx_q < IdxW'(TEXT_CAP - 1));
        if (has_text) idx_d = idx_q + IdxW'(1);
        len_d = len_q - 16'd1;
        if (len_q == 16'd1) begin
          attrs_d   = attrs_q + 3'd1;
          hdr_cnt_d = 3'd0;
          phase_d   = (attrs_d >= 3'(ATTR_COUNT)) ? nad_pkg::PH_TAIL : nad_pkg::PH_ATTR_HDR;
        end
      end
      default: begin
      end
    endcase

    case (phase_d)
      nad_pkg::PH_HEADER:   status = nad_pkg::ST_SHORT;
      nad_pkg::PH_ATTR_HDR: status = nad_pkg::ST_NO_ATTR_HDR;
      nad_pkg::PH_TEXT:     status = nad_pkg::ST_NO_TEXT;
      nad_pkg::PH_TAIL:     status = nad_pkg::ST_COMPLETE;
      default:              status = held_d;
    endcase

    entry_o.has_text   = has_text;
    entry_o.has_status = in_i.in_last;
    entry_o.attr_id    = attr_q;
    entry_o.text_byte  = in_i.in_byte;
    entry_o.text_index = idx_ext[5:0];
    entry_o.status     = status;
    entry_o.uid        = uid_d;
    push_o             = accept && (has_text || in_i.in_last);

    if (in_i.in_last) begin
      phase_d   = nad_pkg::PH_HEADER;
      hdr_cnt_d = 3'd0;
      uid_d     = 32'd0;
      attrs_d   = 3'd0;
      attr_d    = 8'd0;
      len_d     = 16'd0;
      idx_d     = '0;
      held_d    = nad_pkg::ST_COMPLETE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= nad_pkg::PH_HEADER;
      hdr_cnt_q <= 3'd0;
      uid_q     <= 32'd0;
      attrs_q   <= 3'd0;
      attr_q    <= 8'd0;
      len_q     <= 16'd0;
      idx_q     <= '0;
      held_q    <= nad_pkg::ST_COMPLETE;
    end else if (accept) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      uid_q     <= uid_d;
      attrs_q   <= attrs_d;
      attr_q    <= attr_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      held_q    <= held_d;
    end
  end

`ifndef ASSERT_OFF
  a_reject_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == nad_pkg::PH_REJECT |-> held_q != nad_pkg::ST_COMPLETE)
    else $error("rejected packet without a held error");
`endif

endmodule

`default_nettype wire

@@ rtl/nad_fifo.sv @@
// Short request queue between the front and back parts of the deframer.
// Depends on nad_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module nad_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  nad_pkg::entry_t        entry_i,
  input  wire                    pop_i,
  output logic                   full_o,
  output logic                   head_valid_o,
  output nad_pkg::entry_t        head_o
);

  nad_pkg::entry_t                 mem_q [nad_pkg::QDepth];
  logic [nad_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [nad_pkg::QPtrW:0]         count_q;

  assign full_o       = (count_q == (nad_pkg::QPtrW + 1)'(nad_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + (nad_pkg::QPtrW)'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + (nad_pkg::QPtrW)'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + (nad_pkg::QPtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (nad_pkg::QPtrW + 1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("request popped from an empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/nad_back.sv @@
// Back part: turns queued requests into text and status results, one per cycle while the output accepts them.
// Depends on nad_pkg and nad_out_if.
`timescale 1ns / 1ps
`default_nettype none

module nad_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             head_valid_i,
  input  nad_pkg::entry_t head_i,
  output logic            pop_o,
  nad_out_if.source       out_o
);

  logic        valid_q, valid_d;
  logic        sent_q, sent_d;
  logic        kind_q, kind_d;
  logic [7:0]  attr_q, attr_d;
  logic [7:0]  byte_q, byte_d;
  logic [5:0]  index_q, index_d;
  logic [2:0]  status_q, status_d;
  logic [31:0] uid_q, uid_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !valid_q || out_o.ready;

  always_comb begin
    valid_d  = valid_q && !out_o.ready;
    sent_d   = sent_q;
    kind_d   = kind_q;
    attr_d   = attr_q;
    byte_d   = byte_q;
    index_d  = index_q;
    status_d = status_q;
    uid_d    = uid_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load && head_valid_i) begin
      valid_d = 1'b1;
      if (head_i.has_text && !sent_q) begin
        kind_d   = nad_pkg::OutText;
        attr_d   = head_i.attr_id;
        byte_d   = head_i.text_byte;
        index_d  = head_i.text_index;
        status_d = nad_pkg::ST_COMPLETE;
        uid_d    = 32'd0;
        last_d   = !head_i.has_status;
        sent_d   = head_i.has_status;
        pop_o    = !head_i.has_status;
      end else begin
        kind_d   = nad_pkg::OutStatus;
        attr_d   = 8'd0;
        byte_d   = 8'd0;
        index_d  = 6'd0;
        status_d = head_i.status;
        uid_d    = head_i.uid;
        last_d   = 1'b1;
        sent_d   = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    attr_q   <= attr_d;
    byte_q   <= byte_d;
    index_q  <= index_d;
    status_q <= status_d;
    uid_q    <= uid_d;
    last_q   <= last_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_kind   = kind_q;
  assign out_o.attr_id    = attr_q;
  assign out_o.text_byte  = byte_q;
  assign out_o.text_index = index_q;
  assign out_o.status     = status_q;
  assign out_o.packet_uid = uid_q;
  assign out_o.out_last   = last_q;

`ifndef ASSERT_OFF
  a_sent_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> head_valid_i && head_i.has_status && head_i.has_text)
    else $error("text sent flag without a pending status request");
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q == nad_pkg::OutStatus |-> last_q)
    else $error("status result not marked last");
`endif

endmodule

`default_nettype wire

@@ rtl/notification_attribute_deframer.sv @@
// Top level of the notification attribute deframer: front, queue, back and uid register.
// Depends on nad_pkg, nad_if, nad_front, nad_fifo and nad_back.
//
// Channel  Direction  Payload
// in_i     sink       in_byte, in_last
// out_o    source     out_kind, attr_id, text_byte, text_index, status, packet_uid, out_last
// cfg_i    sink       expected_uid
//
// One byte is accepted per cycle unless the queue is full; results are queued, then registered.
// A final byte that also carries text gives two results, the text result before the status.
// The four-entry request queue absorbs output stalls; input stalls only when it is full.
// Reset returns the walk to the header and clears the expected identifier.
`timescale 1ns / 1ps
`default_nettype none

module notification_attribute_deframer #(
  parameter int unsigned ATTR_COUNT = 5,
  parameter int unsigned TEXT_CAP   = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  nad_in_if.sink     in_i,
  nad_out_if.source  out_o,
  nad_cfg_if.sink    cfg_i
);

  logic [31:0]     expected_uid_q;
  logic            push, pop, full, head_valid;
  nad_pkg::entry_t entry, head;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_uid_q <= 32'd0;
    end else if (cfg_i.valid) begin
      expected_uid_q <= cfg_i.expected_uid;
    end
  end

  nad_front #(
    .ATTR_COUNT (ATTR_COUNT),
    .TEXT_CAP   (TEXT_CAP)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .expected_uid_i (expected_uid_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  nad_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  nad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
